// File: hw/rtl/gdate_pkg.sv
// shared types, constants and calendar functions for the date add/subtract block
package gdate_pkg;

   // field widths
   localparam int DAY_W          = 5;
   localparam int MONTH_W        = 4;
   localparam int YEAR_W         = 14;
   localparam int DAY_COUNT_W    = 16;
   localparam int DAY_COUNT_BITS = 16;
   localparam int ACTION_W       = 2;

   // bus widths
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = ACTION_W;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 1;

   // year range
   localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1);
   localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);

   // month limits
   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

   // divisibility by 25: multiply by the inverse of 25 modulo 2**14
   localparam logic [YEAR_W-1:0] INV_25     = YEAR_W'(7209);
   localparam logic [YEAR_W-1:0] DIV_25_MAX = YEAR_W'(655);

   // action codes
   localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SUB  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NOP  = 2'd3;

   // commands from controller to datapath
   typedef struct packed {
      logic start;
      logic step;
      logic commit;
   } gdate_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic done;
   } gdate_status_type;

   // leap year test
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic [YEAR_W-1:0] prod;
      logic              div4;
      logic              div16;
      logic              div25;
      prod  = YEAR_W'(year * INV_25);
      div4  = (year[1:0] == 2'b00);
      div16 = (year[3:0] == 4'b0000);
      div25 = (prod <= DIV_25_MAX);
      return (div4 && !div25) || (div16 && div25);
   endfunction

   // length of a month
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic               leap);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd2:                   len = leap ? DAY_W'(29) : DAY_W'(28);
         4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
         default:                len = DAY_W'(31);
      endcase
      return len;
   endfunction

endpackage

// File: hw/rtl/gdate_ctrl.sv
// controller state machine for the date add/subtract block
module gdate_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  gdate_pkg::gdate_status_type status,
   output gdate_pkg::gdate_cmd_type    cmd
);
   import gdate_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic slot_free;

   // output slot can take a word when empty or being drained
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.step   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            priority if (!status.done) begin
               cmd.step = 1'b1;
            end else if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               // finished walk waits for the output slot
               state_in = ST_WALK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/gdate_dpath.sv
// datapath of the date add/subtract block: held date, month walk and result word
module gdate_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gdate_pkg::gdate_cmd_type              cmd,
   output gdate_pkg::gdate_status_type           status,
   input  logic [gdate_pkg::ACTION_W-1:0]        action,
   input  logic [gdate_pkg::DAY_W-1:0]           load_day,
   input  logic [gdate_pkg::MONTH_W-1:0]         load_month,
   input  logic [gdate_pkg::YEAR_W-1:0]          load_year,
   input  logic [gdate_pkg::DAY_COUNT_W-1:0]     day_count,
   output logic [gdate_pkg::DAY_W-1:0]           out_day,
   output logic [gdate_pkg::MONTH_W-1:0]         out_month,
   output logic [gdate_pkg::YEAR_W-1:0]          out_year,
   output logic                                  range_error
);
   import gdate_pkg::*;

   // held date
   logic [DAY_W-1:0]   cur_day_ff;
   logic [MONTH_W-1:0] cur_month_ff;
   logic [YEAR_W-1:0]  cur_year_ff;

   // working date, remaining count, error and direction
   logic [DAY_W-1:0]          wd_ff, wd_in;
   logic [MONTH_W-1:0]        wm_ff, wm_in;
   logic [YEAR_W-1:0]         wy_ff, wy_in;
   logic [DAY_COUNT_BITS-1:0] n_ff, n_in;
   logic                      err_ff, err_in;
   logic                      sub_ff, sub_in;

   // result word
   logic [DAY_W-1:0]   out_day_ff;
   logic [MONTH_W-1:0] out_month_ff;
   logic [YEAR_W-1:0]  out_year_ff;
   logic               out_err_ff;

   // load saturation
   logic [MONTH_W-1:0] ld_month;
   logic [YEAR_W-1:0]  ld_year;
   logic [DAY_W-1:0]   ld_dim;
   logic [DAY_W-1:0]   ld_day;

   // walk step
   logic                      leap;
   logic [DAY_W-1:0]          dim_cur;
   logic [DAY_W-1:0]          dim_prev;
   logic [DAY_W:0]            rest_inc;
   logic [DAY_W-1:0]          rest;
   logic [DAY_COUNT_BITS-1:0] n_day;

   // clamp a loaded date into a valid one
   always_comb begin
      ld_month = load_month;
      if (load_month < MONTH_JAN) ld_month = MONTH_JAN;
      if (load_month > MONTH_DEC) ld_month = MONTH_DEC;
      ld_year = load_year;
      if (load_year < YEAR_MIN) ld_year = YEAR_MIN;
      if (load_year > YEAR_MAX) ld_year = YEAR_MAX;
      ld_dim = month_days(ld_month, is_leap(ld_year));
      ld_day = load_day;
      if (load_day < DAY_W'(1)) ld_day = DAY_W'(1);
      if (load_day > ld_dim)    ld_day = ld_dim;
   end

   // month lengths around the working date
   assign leap     = is_leap(wy_ff);
   assign dim_cur  = month_days(wm_ff, leap);
   assign dim_prev = (wm_ff <= MONTH_JAN) ? DAY_W'(31) : month_days(wm_ff - MONTH_W'(1), leap);
   assign rest     = dim_cur - wd_ff;
   assign rest_inc = {1'b0, rest} + (DAY_W+1)'(1);
   assign n_day    = DAY_COUNT_BITS'(wd_ff);

   assign status.done = (n_ff == '0) || err_ff;

   // next working state
   always_comb begin
      wd_in  = wd_ff;
      wm_in  = wm_ff;
      wy_in  = wy_ff;
      n_in   = n_ff;
      err_in = err_ff;
      sub_in = sub_ff;
      priority if (cmd.start) begin
         err_in = 1'b0;
         sub_in = (action == ACT_SUB);
         wd_in  = cur_day_ff;
         wm_in  = cur_month_ff;
         wy_in  = cur_year_ff;
         n_in   = '0;
         unique case (action)
            ACT_LOAD: begin
               wd_in = ld_day;
               wm_in = ld_month;
               wy_in = ld_year;
            end
            ACT_ADD, ACT_SUB: n_in = day_count[DAY_COUNT_BITS-1:0];
            default:          n_in = '0;
         endcase
      end else if (cmd.step) begin
         if (!sub_ff) begin
            // forward: finish this month or move to the first of the next
            if (n_ff > DAY_COUNT_BITS'(rest)) begin
               n_in  = n_ff - DAY_COUNT_BITS'(rest_inc);
               wd_in = DAY_W'(1);
               if (wm_ff >= MONTH_DEC) begin
                  wm_in = MONTH_JAN;
                  wy_in = wy_ff + YEAR_W'(1);
                  if (wy_ff >= YEAR_MAX) err_in = 1'b1;
               end else begin
                  wm_in = wm_ff + MONTH_W'(1);
               end
            end else begin
               wd_in = wd_ff + DAY_W'(n_ff);
               n_in  = '0;
            end
         end else begin
            // backward: step to the last day of the previous month, or back within this month
            if (n_ff >= n_day) begin
               n_in  = n_ff - n_day;
               wd_in = dim_prev;
               if (wm_ff <= MONTH_JAN) begin
                  wm_in = MONTH_DEC;
                  if (wy_ff <= YEAR_MIN) begin
                     err_in = 1'b1;
                  end else begin
                     wy_in = wy_ff - YEAR_W'(1);
                  end
               end else begin
                  wm_in = wm_ff - MONTH_W'(1);
               end
            end else begin
               wd_in = wd_ff - DAY_W'(n_ff);
               n_in  = '0;
            end
         end
      end else begin
         // no command: hold the working state
         n_in = n_ff;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      wd_ff  <= wd_in;
      wm_ff  <= wm_in;
      wy_ff  <= wy_in;
      n_ff   <= n_in;
      err_ff <= err_in;
      sub_ff <= sub_in;
   end

   // held date, updated on commit unless the walk left the year range
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_day_ff   <= DAY_W'(1);
         cur_month_ff <= MONTH_JAN;
         cur_year_ff  <= YEAR_MIN;
      end else if (cmd.commit && !err_ff) begin
         cur_day_ff   <= wd_ff;
         cur_month_ff <= wm_ff;
         cur_year_ff  <= wy_ff;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_day_ff   <= err_ff ? cur_day_ff   : wd_ff;
         out_month_ff <= err_ff ? cur_month_ff : wm_ff;
         out_year_ff  <= err_ff ? cur_year_ff  : wy_ff;
         out_err_ff   <= err_ff;
      end
   end

   assign out_day     = out_day_ff;
   assign out_month   = out_month_ff;
   assign out_year    = out_year_ff;
   assign range_error = out_err_ff;

endmodule

// File: hw/rtl/gregorian_date_add_subtract_days.sv
// top level of the Gregorian date add/subtract block
//
// Holds one calendar date. Each request word loads a date, adds a day count,
// subtracts one or keeps the date; each request returns exactly one response
// word with the date held afterwards and a range error flag.
// req channel: req_tuser carries the action, req_tdata the load date and count.
// rsp channel: rsp_tdata carries the date, rsp_tuser the range error flag.
// Walk: a load, an unused action or a zero count needs no month walk; add and
// subtract step through the month walk, which handles one month per cycle
// (a count of 65535 crosses about 2150 months).
// Flow: one request is worked at a time; req_tready is high only while
// idle, so the next request is accepted only after the response is
// registered. A finished response waits in the output register while the
// next request is accepted and worked.
// When the receiver stalls, a finished walk holds until the output register
// frees up; the response payload stays stable while rsp_tvalid is high.
// Reset sets the date to 1 January of year 1 and drops any pending response.
module gregorian_date_add_subtract_days (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // load_day[4:0], load_month[8:5], load_year[22:9], day_count[38:23], zero[39]
   input  logic [gdate_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [gdate_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_day[4:0], out_month[8:5], out_year[22:9], zero[23]
   output logic [gdate_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // range_error[0]
   output logic [gdate_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import gdate_pkg::*;

   gdate_cmd_type    cmd;
   gdate_status_type status;

   logic [DAY_W-1:0]   out_day;
   logic [MONTH_W-1:0] out_month;
   logic [YEAR_W-1:0]  out_year;
   logic               range_error;

   // sequencing and handshakes
   gdate_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // date registers and month walk
   gdate_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .action      (req_tuser[ACTION_W-1:0]),
      .load_day    (req_tdata[4:0]),
      .load_month  (req_tdata[8:5]),
      .load_year   (req_tdata[22:9]),
      .day_count   (req_tdata[38:23]),
      .out_day     (out_day),
      .out_month   (out_month),
      .out_year    (out_year),
      .range_error (range_error)
   );

   // pack the response word
   assign rsp_tdata = {1'b0, out_year, out_month, out_day};
   assign rsp_tuser = range_error;

endmodule
